// ----- hw/rtl/swd_pkg.sv -----
// Shared types, constants and functions of the six-word dictionary codec.
package swd_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 2048;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SRCH_W        = IDX_W + 1;              // probe index incl. overflow bit
  localparam int STEP_W        = $clog2(IDX_W + 1);
  localparam int CHARS_W       = 32;
  localparam int LEN_W         = 3;
  localparam int ENTRY_W       = CHARS_W + LEN_W;
  localparam int POS_W         = 3;
  localparam int VALUE_W       = 64;
  localparam int REQ_W         = 2;
  localparam int ENC_K_W       = 3;

  // Binary search constants
  localparam logic [SRCH_W-1:0] MID_IDX   = SRCH_W'(TABLE_ENTRIES / 2);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W);
  localparam logic [STEP_W-1:0] HALF_LAST = STEP_W'(IDX_W - 1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd2;

  // Phrase positions and lengths
  localparam logic [POS_W-1:0]   POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0]   POS_LAST  = 3'd5;
  localparam logic [LEN_W-1:0]   LEN_EMPTY = 3'd0;
  localparam logic [LEN_W-1:0]   LEN_FULL  = 3'd4;
  localparam logic [ENC_K_W-1:0] ENC_LAST  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_QRES,
    ST_ENC
  } state_t;

  typedef enum logic [1:0] {
    ORD_LT,
    ORD_EQ,
    ORD_GT
  } ord_t;

  // Request from the top level to the phrase accumulator
  typedef struct packed {
    logic             update;
    logic [POS_W-1:0] pos;
    logic             found;
    logic [IDX_W-1:0] idx;
  } phr_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
  } phr_res_t;

  // Keep only the first len characters; lengths above four keep all
  function automatic logic [CHARS_W-1:0] swd_mask(input logic [CHARS_W-1:0] c,
                                                  input logic [LEN_W-1:0]   len);
    logic [CHARS_W-1:0] m;
    unique case (len)
      3'd0:    m = '0;
      3'd1:    m = {c[31:24], 24'd0};
      3'd2:    m = {c[31:16], 16'd0};
      3'd3:    m = {c[31:8], 8'd0};
      default: m = c;
    endcase
    return m;
  endfunction

  // Dictionary order of a query against a stored entry
  function automatic ord_t swd_order(input logic [CHARS_W-1:0] qc,
                                     input logic [LEN_W-1:0]   ql,
                                     input logic [ENTRY_W-1:0] entry);
    logic [LEN_W-1:0]   tl;
    logic [CHARS_W-1:0] tc;
    logic [CHARS_W-1:0] qm;
    logic               qg;
    logic               tg;
    ord_t               o;
    tl = entry[LEN_W-1:0];
    tc = swd_mask(entry[ENTRY_W-1:LEN_W], tl);
    qm = swd_mask(qc, ql);
    qg = (ql == LEN_FULL);
    tg = (tl == LEN_FULL);
    if (tl == LEN_EMPTY) begin
      o = ORD_GT;
    end else if (qg != tg) begin
      o = qg ? ORD_GT : ORD_LT;
    end else if (qm != tc) begin
      o = (qm > tc) ? ORD_GT : ORD_LT;
    end else if (ql != tl) begin
      o = (ql > tl) ? ORD_GT : ORD_LT;
    end else begin
      o = ORD_EQ;
    end
    return o;
  endfunction

  // Sum of the 32 two-bit pairs, modulo four
  function automatic logic [1:0] swd_parity(input logic [VALUE_W-1:0] v);
    logic [VALUE_W/2-1:0] lo;
    logic [VALUE_W/2-1:0] hi;
    logic [6:0]           cl;
    logic [6:0]           ch;
    for (int i = 0; i < VALUE_W / 2; i++) begin
      lo[i] = v[2*i];
      hi[i] = v[2*i+1];
    end
    cl = 7'($countones(lo));
    ch = 7'($countones(hi));
    return cl[1:0] + {ch[0], 1'b0};
  endfunction

  // Table index of the k-th word of an encoded value
  function automatic logic [IDX_W-1:0] swd_enc_idx(input logic [VALUE_W-1:0] v,
                                                   input logic [ENC_K_W-1:0] k);
    logic [IDX_W-1:0] r;
    unique case (k)
      3'd0:    r = v[63:53];
      3'd1:    r = v[52:42];
      3'd2:    r = v[41:31];
      3'd3:    r = v[30:20];
      3'd4:    r = v[19:9];
      default: r = {v[8:0], swd_parity(v)};
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/swd_in_if.sv -----
// Input channel of the six-word dictionary codec.
interface swd_in_if import swd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [IDX_W-1:0]   entry_index;
  logic [CHARS_W-1:0] word_chars;
  logic [LEN_W-1:0]   word_length;
  logic [POS_W-1:0]   word_position;
  logic [VALUE_W-1:0] value_in;

  modport source (
    output valid, req_type, entry_index, word_chars, word_length, word_position, value_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, word_chars, word_length, word_position, value_in,
    output ready
  );
endinterface

// ----- hw/rtl/swd_out_if.sv -----
// Result channel of the six-word dictionary codec.
interface swd_out_if import swd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   word_index;
  logic               found;
  logic [CHARS_W-1:0] out_chars;
  logic [LEN_W-1:0]   out_length;
  logic [VALUE_W-1:0] decoded_value;
  logic               value_valid;
  logic               last;

  modport source (
    output valid, word_index, found, out_chars, out_length, decoded_value, value_valid, last,
    input  ready
  );
  modport sink (
    input  valid, word_index, found, out_chars, out_length, decoded_value, value_valid, last,
    output ready
  );
endinterface

// ----- hw/rtl/swd_phrase.sv -----
// Six-word phrase accumulator: merges query indices and checks parity.
module swd_phrase import swd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  phr_req_t req,
  output phr_res_t res
);

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               flag_r, flag_nxt;

  // Next accumulator and flag for the word at req.pos
  always_comb begin
    acc_nxt  = acc_r;
    flag_nxt = flag_r;
    unique case (req.pos)
      POS_FIRST: begin
        acc_nxt  = req.found ? {req.idx, 53'd0} : '0;
        flag_nxt = req.found;
      end
      3'd1: begin
        if (req.found) acc_nxt = acc_r | {11'd0, req.idx, 42'd0};
        flag_nxt = flag_r & req.found;
      end
      3'd2: begin
        if (req.found) acc_nxt = acc_r | {22'd0, req.idx, 31'd0};
        flag_nxt = flag_r & req.found;
      end
      3'd3: begin
        if (req.found) acc_nxt = acc_r | {33'd0, req.idx, 20'd0};
        flag_nxt = flag_r & req.found;
      end
      3'd4: begin
        if (req.found) acc_nxt = acc_r | {44'd0, req.idx, 9'd0};
        flag_nxt = flag_r & req.found;
      end
      POS_LAST: begin
        if (req.found) acc_nxt = acc_r | {55'd0, req.idx[IDX_W-1:2]};
        flag_nxt = flag_r & req.found;
      end
      default: ;  // beyond the phrase: lookup only
    endcase
  end

  // Report at the sixth word only
  always_comb begin
    res.value = (req.pos == POS_LAST) ? acc_nxt : '0;
    res.ok    = (req.pos == POS_LAST) && flag_nxt && req.found &&
                (swd_parity(acc_nxt) == req.idx[1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      flag_r <= 1'b1;
    end else if (req.update) begin
      acc_r  <= acc_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

// ----- hw/rtl/otp_six_word_dictionary_codec_top.sv -----
// Top level of the six-word dictionary codec: word table, search and encode control.
//
// Usage:
//   in_ch  (valid/ready) takes load, query and encode items; out_ch (valid/ready)
//   returns results. Load items write one table entry and return nothing. A query
//   returns one result after its binary search: one table probe per cycle, at
//   most twelve probes. An empty query word skips the search. An encode item
//   returns six results, one per cycle while out_ch is ready; each reads one
//   table entry. The table is a 2048-entry single-write, single-read memory
//   with a registered read; the probe loop through that read port sets the
//   query time. One item is in work at a time; the next is taken as soon as
//   the last result of the current item sits in the output register, even if
//   it is not taken. A stalled receiver holds the output register and the
//   control waits. Reset clears the control, the output valid, the
//   accumulator and sets the all-found flag; table contents are undefined
//   until loaded.
module otp_six_word_dictionary_codec_top import swd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  swd_in_if.sink    in_ch,
  swd_out_if.source out_ch
);

  state_t             state_r, state_nxt;
  logic               in_acc;
  logic               out_free;
  logic               emit;

  // Query and encode work registers
  logic [CHARS_W-1:0] qchars_r;
  logic [LEN_W-1:0]   qlen_r;
  logic [POS_W-1:0]   qpos_r;
  logic               qfound_r;
  logic [SRCH_W-1:0]  idx_r;
  logic [STEP_W-1:0]  step_r;
  logic [VALUE_W-1:0] value_r;
  logic [ENC_K_W-1:0] k_r;

  // Table
  logic [ENTRY_W-1:0] table_mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   rd_addr;

  // Search step
  ord_t               ord;
  logic [SRCH_W-1:0]  delta;
  logic [SRCH_W-1:0]  idx_step;
  logic               hit;
  logic               miss;
  logic [ENC_K_W-1:0] k_sel;

  // Output register
  logic               out_valid_r;
  logic [IDX_W-1:0]   o_index_r, o_index_nxt;
  logic               o_found_r, o_found_nxt;
  logic [CHARS_W-1:0] o_chars_r, o_chars_nxt;
  logic [LEN_W-1:0]   o_len_r, o_len_nxt;
  logic [VALUE_W-1:0] o_value_r, o_value_nxt;
  logic               o_vvalid_r, o_vvalid_nxt;
  logic               o_last_r, o_last_nxt;

  phr_req_t           phr_req;
  phr_res_t           phr_res;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Probe compare and next probe index
  always_comb begin
    ord      = swd_order(qchars_r, qlen_r, rd_data_r);
    delta    = (step_r < HALF_LAST) ? (MID_IDX >> (step_r + STEP_W'(1))) : SRCH_W'(1);
    idx_step = (ord == ORD_GT) ? (idx_r + delta) : (idx_r - delta);
    hit      = (ord == ORD_EQ);
    miss     = !hit && ((step_r == LAST_STEP) || idx_step[SRCH_W-1]);
  end

  // Control: next state, read address and result
  always_comb begin
    state_nxt    = state_r;
    rd_addr      = MID_IDX[IDX_W-1:0];
    emit         = 1'b0;
    k_sel        = k_r;
    o_index_nxt  = '0;
    o_found_nxt  = 1'b0;
    o_chars_nxt  = '0;
    o_len_nxt    = '0;
    o_value_nxt  = '0;
    o_vvalid_nxt = 1'b0;
    o_last_nxt   = 1'b0;
    phr_req.update = 1'b0;
    phr_req.pos    = qpos_r;
    phr_req.found  = qfound_r;
    phr_req.idx    = idx_r[IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && (in_ch.req_type == REQ_ENCODE)) begin
          rd_addr = swd_enc_idx(in_ch.value_in, '0);
        end
        if (in_acc) begin
          priority if (in_ch.req_type == REQ_QUERY) begin
            state_nxt = (in_ch.word_length == LEN_EMPTY) ? ST_QRES : ST_SEARCH;
          end else if (in_ch.req_type == REQ_ENCODE) begin
            state_nxt = ST_ENC;
          end else begin
            state_nxt = ST_IDLE;  // load or unused code: no result
          end
        end
      end
      ST_SEARCH: begin
        rd_addr = idx_step[IDX_W-1:0];
        if (hit || miss) state_nxt = ST_QRES;
      end
      ST_QRES: begin
        if (out_free) begin
          emit           = 1'b1;
          phr_req.update = 1'b1;
          o_index_nxt    = qfound_r ? idx_r[IDX_W-1:0] : '0;
          o_found_nxt    = qfound_r;
          o_value_nxt    = phr_res.value;
          o_vvalid_nxt   = phr_res.ok;
          o_last_nxt     = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_ENC: begin
        // Fetch the next word when this one leaves, else re-read it
        if (out_free) begin
          emit        = 1'b1;
          k_sel       = k_r + ENC_K_W'(1);
          o_index_nxt = swd_enc_idx(value_r, k_r);
          o_chars_nxt = rd_data_r[ENTRY_W-1:LEN_W];
          o_len_nxt   = rd_data_r[LEN_W-1:0];
          o_last_nxt  = (k_r == ENC_LAST);
          if (k_r == ENC_LAST) state_nxt = ST_IDLE;
        end
        rd_addr = swd_enc_idx(value_r, k_sel);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Word table: load writes, one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.req_type == REQ_LOAD)) begin
      table_mem[in_ch.entry_index] <= {in_ch.word_chars, in_ch.word_length};
    end
    rd_data_r <= table_mem[rd_addr];
  end

  // Query latch and search progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      qfound_r <= 1'b0;
    end else if (in_acc && (in_ch.req_type == REQ_QUERY)) begin
      step_r   <= '0;
      qfound_r <= 1'b0;
    end else if (state_r == ST_SEARCH) begin
      if (hit) qfound_r <= 1'b1;
      else if (!miss) step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.req_type == REQ_QUERY)) begin
      qchars_r <= in_ch.word_chars;
      qlen_r   <= in_ch.word_length;
      qpos_r   <= in_ch.word_position;
      idx_r    <= MID_IDX;
    end else if ((state_r == ST_SEARCH) && !hit && !miss) begin
      idx_r <= idx_step;
    end
  end

  // Encode word counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (in_acc && (in_ch.req_type == REQ_ENCODE)) begin
      k_r <= '0;
    end else if ((state_r == ST_ENC) && out_free && (k_r != ENC_LAST)) begin
      k_r <= k_r + ENC_K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.req_type == REQ_ENCODE)) value_r <= in_ch.value_in;
  end

  swd_phrase u_phrase (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (phr_req),
    .res   (phr_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (emit)         out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_index_r  <= o_index_nxt;
      o_found_r  <= o_found_nxt;
      o_chars_r  <= o_chars_nxt;
      o_len_r    <= o_len_nxt;
      o_value_r  <= o_value_nxt;
      o_vvalid_r <= o_vvalid_nxt;
      o_last_r   <= o_last_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.word_index    = o_index_r;
  assign out_ch.found         = o_found_r;
  assign out_ch.out_chars     = o_chars_r;
  assign out_ch.out_length    = o_len_r;
  assign out_ch.decoded_value = o_value_r;
  assign out_ch.value_valid   = o_vvalid_r;
  assign out_ch.last          = o_last_r;

endmodule

// ----- hw/rtl/swd_checker.sv -----
// Port-level assertions of the six-word dictionary codec and their bind.
module swd_checker import swd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [REQ_W-1:0]   in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic [IDX_W-1:0]   out_word_index,
  input logic               out_found,
  input logic [LEN_W-1:0]   out_length,
  input logic               out_value_valid,
  input logic               out_last
);

  // No result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted encode item closes the input
  a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == REQ_ENCODE)) |=> !in_ready)
    else $error("input reopened during encode");

  // A found word is a single query result
  a_found_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_last && (out_length == LEN_EMPTY)))
    else $error("found flag on a non-query result");

  // A valid decoded value needs the last word found
  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_valid) |-> (out_found && out_last))
    else $error("value valid without a found word");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word_index) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind otp_six_word_dictionary_codec_top swd_checker u_swd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_req_type     (in_ch.req_type),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_word_index  (out_ch.word_index),
  .out_found       (out_ch.found),
  .out_length      (out_ch.out_length),
  .out_value_valid (out_ch.value_valid),
  .out_last        (out_ch.last)
);

// ----- dv/otp_six_word_dictionary_codec_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking test of the six-word dictionary codec: sorted table load, lookups, phrases, encodes.
module otp_six_word_dictionary_codec_top_test;
  import swd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SHORT_WORDS  = 571;
  localparam int PHASE_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 3_000_000;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [IDX_W-1:0]   entry;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } codec_req_t;

  localparam int REQ_BITS = $bits(codec_req_t);

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic               found;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
    logic               value_ok;
    logic               last;
  } codec_res_t;

  typedef enum int {PHRASE_CLEAN, PHRASE_MISSING_WORD, PHRASE_BAD_PARITY} phrase_flaw_t;

  // Predicts codec results and checks the result stream in order
  class phrase_scoreboard;
    logic [ENTRY_W-1:0] words [TABLE_ENTRIES];
    logic [VALUE_W-1:0] phrase_value;
    bit                 phrase_all_found;
    codec_res_t         expected_words [$];
    int                 mismatches;

    function new();
      phrase_value     = '0;
      phrase_all_found = 1'b1;
      mismatches       = 0;
    endfunction

    function logic [CHARS_W-1:0] keep_chars(input logic [CHARS_W-1:0] c,
                                            input logic [LEN_W-1:0]   len);
      if (len == LEN_EMPTY) return '0;
      if (len >= LEN_FULL) return c;
      return c & ~(32'hFFFF_FFFF >> (8 * len));
    endfunction

    // Sign of query minus entry: short words first, then byte-wise, then length
    function int word_order(input logic [CHARS_W-1:0] qc, input logic [LEN_W-1:0] ql,
                            input logic [ENTRY_W-1:0] ent);
      logic [LEN_W-1:0]   tl;
      logic [CHARS_W-1:0] tc;
      logic [CHARS_W-1:0] qm;
      tl = ent[LEN_W-1:0];
      tc = keep_chars(ent[ENTRY_W-1:LEN_W], tl);
      qm = keep_chars(qc, ql);
      if (tl == LEN_EMPTY) return 1;
      if ((ql == LEN_FULL) != (tl == LEN_FULL)) return (ql == LEN_FULL) ? 1 : -1;
      if (qm != tc) return (qm > tc) ? 1 : -1;
      if (ql != tl) return (ql > tl) ? 1 : -1;
      return 0;
    endfunction

    // Fixed-probe binary search starting at the middle of the table
    function bit dict_lookup(input logic [CHARS_W-1:0] qc, input logic [LEN_W-1:0] ql,
                             output logic [IDX_W-1:0] hit);
      int at;
      int span;
      int ord;
      hit  = '0;
      at   = TABLE_ENTRIES / 2;
      span = TABLE_ENTRIES / 2;
      if (ql == LEN_EMPTY) return 1'b0;
      for (int p = 0; p < 16; p++) begin
        if (at < 0 || at >= TABLE_ENTRIES) return 1'b0;
        ord = word_order(qc, ql, words[at]);
        if (ord == 0) begin
          hit = IDX_W'(at);
          return 1'b1;
        end
        if (span == 0) return 1'b0;
        span = span / 2;
        if (ord > 0) at += (span != 0) ? span : 1;
        else at -= (span != 0) ? span : 1;
      end
      return 1'b0;
    endfunction

    function logic [1:0] pair_parity(input logic [VALUE_W-1:0] v);
      logic [1:0] s;
      s = '0;
      for (int i = 0; i < VALUE_W / 2; i++) s += v[2*i +: 2];
      return s;
    endfunction

    // Accepted input item: update state and queue the results it causes
    function void note_item(input codec_req_t it);
      logic [IDX_W-1:0]   hit;
      logic [IDX_W-1:0]   widx;
      logic [ENTRY_W-1:0] ent;
      logic [VALUE_W-1:0] dv;
      bit                 f;
      bit                 ok;
      case (it.req)
        REQ_LOAD: begin
          words[it.entry] = {it.chars, it.len};
        end
        REQ_QUERY: begin
          f  = dict_lookup(it.chars, it.len, hit);
          dv = '0;
          ok = 1'b0;
          if (it.pos == POS_FIRST) begin
            phrase_value     = f ? {hit, 53'd0} : '0;
            phrase_all_found = f;
          end else if (it.pos < POS_LAST) begin
            if (f) phrase_value |= VALUE_W'(hit) << (VALUE_W - (it.pos + 1) * IDX_W);
            else phrase_all_found = 1'b0;
          end else if (it.pos == POS_LAST) begin
            if (f) phrase_value |= VALUE_W'(hit >> 2);
            else phrase_all_found = 1'b0;
            dv = phrase_value;
            ok = phrase_all_found && f && (pair_parity(phrase_value) == hit[1:0]);
          end
          expected_words.push_back('{index: hit, found: f, chars: '0, len: '0,
                                     value: dv, value_ok: ok, last: 1'b1});
        end
        REQ_ENCODE: begin
          for (int k = 0; k < 6; k++) begin
            if (k < 5) widx = it.value[53 - IDX_W * k +: IDX_W];
            else widx = {it.value[8:0], pair_parity(it.value)};
            ent = words[widx];
            expected_words.push_back('{index: widx, found: 1'b0,
                                       chars: ent[ENTRY_W-1:LEN_W], len: ent[LEN_W-1:0],
                                       value: '0, value_ok: 1'b0, last: (k == 5)});
          end
        end
        default: ;  // unused request code is dropped
      endcase
    endfunction

    function void report(input string what, input codec_res_t exp, input codec_res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch:%s", $time, what);
        $display("  exp idx=%h found=%b chars=%h len=%0d value=%h ok=%b last=%b",
                 exp.index, exp.found, exp.chars, exp.len, exp.value, exp.value_ok, exp.last);
        $display("  got idx=%h found=%b chars=%h len=%0d value=%h ok=%b last=%b",
                 got.index, got.found, got.chars, got.len, got.value, got.value_ok, got.last);
      end
    endfunction

    function void check_result(input codec_res_t got);
      codec_res_t exp;
      string      diff;
      if (expected_words.size() == 0) begin
        report(" result with nothing expected", '0, got);
        return;
      end
      exp  = expected_words.pop_front();
      diff = "";
      if (got.index !== exp.index) diff = {diff, " word_index"};
      if (got.found !== exp.found) diff = {diff, " found"};
      if (got.chars !== exp.chars) diff = {diff, " out_chars"};
      if (got.len !== exp.len) diff = {diff, " out_length"};
      if (got.value !== exp.value) diff = {diff, " decoded_value"};
      if (got.value_ok !== exp.value_ok) diff = {diff, " value_valid"};
      if (got.last !== exp.last) diff = {diff, " last"};
      if (diff != "") report(diff, exp, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct   = 10;
  int   sink_stall_pct = 62;
  int   items_sent     = 0;

  phrase_scoreboard sb;

  swd_in_if  in_ch ();
  swd_out_if out_ch ();

  otp_six_word_dictionary_codec_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, check every accepted result
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_result(codec_res_t'({out_ch.word_index, out_ch.found, out_ch.out_chars,
                                      out_ch.out_length, out_ch.decoded_value,
                                      out_ch.value_valid, out_ch.last}));
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Random bytes beyond the word length; they never take part in a comparison
  function automatic logic [CHARS_W-1:0] fresh_tail(input logic [CHARS_W-1:0] c,
                                                    input logic [LEN_W-1:0]   len);
    logic [CHARS_W-1:0] tail;
    tail = (len >= LEN_FULL) ? '0 : (32'hFFFF_FFFF >> (8 * len));
    return (c & ~tail) | ($urandom & tail);
  endfunction

  function automatic codec_req_t noise_req();
    codec_req_t it;
    it = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
    it.len = LEN_W'($urandom_range(0, 4));
    it.pos = POS_W'($urandom_range(0, 5));
    return it;
  endfunction

  task automatic send_item(input codec_req_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= it.req;
    in_ch.entry_index   <= it.entry;
    in_ch.word_chars    <= it.chars;
    in_ch.word_length   <= it.len;
    in_ch.word_position <= it.pos;
    in_ch.value_in      <= it.value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    if (it.req != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_load(input int idx, input logic [CHARS_W-1:0] c,
                           input logic [LEN_W-1:0] len);
    codec_req_t it;
    it       = noise_req();
    it.req   = REQ_LOAD;
    it.entry = IDX_W'(idx);
    it.chars = c;
    it.len   = len;
    send_item(it);
  endtask

  task automatic send_query(input logic [CHARS_W-1:0] c, input logic [LEN_W-1:0] len,
                            input logic [POS_W-1:0] pos);
    codec_req_t it;
    it       = noise_req();
    it.req   = REQ_QUERY;
    it.chars = c;
    it.len   = len;
    it.pos   = pos;
    send_item(it);
  endtask

  // Query the word stored at a table index, with new bytes past its length
  task automatic query_entry(input int idx, input logic [POS_W-1:0] pos);
    logic [ENTRY_W-1:0] ent;
    ent = sb.words[idx];
    send_query(fresh_tail(ent[ENTRY_W-1:LEN_W], ent[LEN_W-1:0]), ent[LEN_W-1:0], pos);
  endtask

  task automatic send_encode(input logic [VALUE_W-1:0] v);
    codec_req_t it;
    it       = noise_req();
    it.req   = REQ_ENCODE;
    it.value = v;
    send_item(it);
  endtask

  // Encode a value, then read it back as six queries
  task automatic send_phrase(input logic [VALUE_W-1:0] v, input phrase_flaw_t flaw);
    logic [IDX_W-1:0] widx [6];
    int               bad;
    for (int k = 0; k < 5; k++) widx[k] = v[53 - IDX_W * k +: IDX_W];
    widx[5] = {v[8:0], sb.pair_parity(v)};
    if (flaw == PHRASE_BAD_PARITY) widx[5][1:0] ^= 2'($urandom_range(1, 3));
    bad = $urandom_range(0, 5);
    send_encode(v);
    for (int k = 0; k < 6; k++) begin
      if (flaw == PHRASE_MISSING_WORD && k == bad) begin
        send_query($urandom, LEN_W'($urandom_range(1, 4)), POS_W'(k));
      end else begin
        query_entry(widx[k], POS_W'(k));
      end
    end
  endtask

  // Sender waits until every expected result has come
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
  endtask

  // Sorted dictionary: short words first, then four-character words, all distinct
  task automatic fill_dictionary();
    logic [CHARS_W-1:0] p;
    logic [LEN_W-1:0]   l;
    longint unsigned    room;
    longint unsigned    units;
    p = '0;
    l = 3'd1;
    for (int i = 0; i < SHORT_WORDS; i++) begin
      if (i > 0) begin
        if (l < 3'd3 && $urandom_range(0, 3) == 0) begin
          l++;
        end else begin
          room  = (64'hFFFF_FF00 - p) >> 8;
          units = room / (SHORT_WORDS - i + 2);
          p     = p + ((1 + $urandom_range(0, 32'(2 * units))) << 8);
          l     = (p[15:8] != 0) ? 3'd3 : (p[23:16] != 0) ? 3'd2 : 3'd1;
        end
      end
      send_load(i, $urandom_range(0, 1) ? fresh_tail(p, l) : p, l);
    end
    p = '0;
    for (int i = SHORT_WORDS; i < TABLE_ENTRIES; i++) begin
      if (i == TABLE_ENTRIES - 1) begin
        p = 32'hFFFF_FFFF;
      end else if (i > SHORT_WORDS) begin
        room  = 64'hFFFF_FFFF - p;
        units = room / (TABLE_ENTRIES - i + 2);
        p     = p + 1 + $urandom_range(0, 32'(2 * units));
      end
      send_load(i, p, LEN_FULL);
    end
  endtask

  task automatic random_query();
    logic [POS_W-1:0] pos;
    int               pick;
    pos  = ($urandom_range(0, 9) < 9) ? POS_W'($urandom_range(0, 5))
                                      : POS_W'($urandom_range(6, 7));
    pick = $urandom_range(0, 9);
    if (pick < 6) query_entry($urandom_range(0, TABLE_ENTRIES - 1), pos);
    else if (pick < 9) send_query($urandom, LEN_W'($urandom_range(0, 4)), pos);
    else send_query($urandom, LEN_EMPTY, pos);
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct);
    int           goal;
    int           pick;
    phrase_flaw_t flaw;
    codec_req_t   it;
    logic [ENTRY_W-1:0] ent;
    int           idx;
    hold_until_drained();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        flaw = ($urandom_range(0, 99) < 70) ? PHRASE_CLEAN :
               ($urandom_range(0, 1) != 0) ? PHRASE_MISSING_WORD : PHRASE_BAD_PARITY;
        send_phrase({$urandom, $urandom}, flaw);
      end else if (pick < 70) begin
        random_query();
      end else if (pick < 80) begin
        send_encode({$urandom, $urandom});
      end else if (pick < 92) begin
        // rewrite an entry with the same word, new trailing bytes
        idx = $urandom_range(0, TABLE_ENTRIES - 1);
        ent = sb.words[idx];
        send_load(idx, fresh_tail(ent[ENTRY_W-1:LEN_W], ent[LEN_W-1:0]), ent[LEN_W-1:0]);
      end else begin
        it     = noise_req();
        it.req = REQ_UNUSED;
        send_item(it);
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [ENTRY_W-1:0] saved;
    codec_req_t         it;
    sb                  = new();
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_LOAD;
    in_ch.entry_index   = '0;
    in_ch.word_chars    = '0;
    in_ch.word_length   = LEN_EMPTY;
    in_ch.word_position = POS_FIRST;
    in_ch.value_in      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    fill_dictionary();
    hold_until_drained();

    // Directed items
    it     = noise_req();
    it.req = REQ_UNUSED;
    send_item(it);
    send_query($urandom, LEN_EMPTY, POS_FIRST);
    query_entry(0, POS_FIRST);
    query_entry(TABLE_ENTRIES - 1, 3'd1);
    send_query(32'hFFFF_FFFF, LEN_FULL, 3'd2);
    send_query(32'h0000_0000, LEN_FULL, 3'd3);
    query_entry(SHORT_WORDS, POS_LAST);
    query_entry($urandom_range(0, TABLE_ENTRIES - 1), 3'd6);
    query_entry($urandom_range(0, TABLE_ENTRIES - 1), 3'd7);
    send_encode('0);
    send_encode('1);
    send_phrase('1, PHRASE_CLEAN);
    // empty entry at the first probe point sorts below every query
    saved = sb.words[TABLE_ENTRIES / 2];
    send_load(TABLE_ENTRIES / 2, $urandom, LEN_EMPTY);
    send_query($urandom, LEN_FULL, POS_FIRST);
    send_load(TABLE_ENTRIES / 2, saved[ENTRY_W-1:LEN_W], saved[LEN_W-1:0]);

    // Random items under three idling patterns
    random_phase(10, 62);
    random_phase(62, 10);
    random_phase(0, 0);

    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
